// File: rtl/pcgb_pkg.sv
// ----------------------------------------------------------------------------
// pcgb_pkg
// Shared types, constants and codes of the PCG32 bounded random core.
// ----------------------------------------------------------------------------
package pcgb_pkg;

	localparam int WORD_W  = 32;
	localparam int STATE_W = 64;

	localparam logic [STATE_W-1:0] PCG_DEFAULT_STATE  = 64'h853c49e6748fea9b;
	localparam logic [STATE_W-1:0] PCG_DEFAULT_STREAM = 64'hda3e39cb94b95bdb;
	localparam logic [STATE_W-1:0] PCG_MULTIPLIER     = 64'h5851f42d4c957f2d;

	// XSH-RR shift amounts
	localparam int XSH_SHIFT = 18;
	localparam int XSH_LOW   = 27;
	localparam int ROT_LOW   = 59;

	// input item commands
	localparam logic [1:0] CMD_RAW     = 2'd0;
	localparam logic [1:0] CMD_BOUNDED = 2'd1;
	localparam logic [1:0] CMD_REINIT  = 2'd2;

	// register indexes (paddr bit 3)
	localparam logic REG_USE_SEED   = 1'b0;
	localparam logic REG_SEED_VALUE = 1'b1;

	typedef enum logic [2:0] {
		LCG_NONE,
		LCG_STEP,
		LCG_LOAD_DEFAULT,
		LCG_LOAD_SEED,
		LCG_ADD_DEFAULT
	} lcg_op_t;

	typedef struct packed {
		lcg_op_t op;
	} lcg_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RAW_WAIT,
		ST_THRESH_START,
		ST_THRESH_WAIT,
		ST_DRAW,
		ST_DRAW_WAIT,
		ST_MOD_WAIT,
		ST_SEED_STEP1,
		ST_SEED_WAIT1,
		ST_SEED_STEP2,
		ST_SEED_WAIT2,
		ST_FINISH
	} seq_state_t;

endpackage

// File: rtl/pcgb_lcg.sv
// ----------------------------------------------------------------------------
// pcgb_lcg
// LCG state, stream increment and XSH-RR output. One step advances the
// state through a single shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module pcgb_lcg import pcgb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  lcg_ctrl_t           ctrl,
	input  logic [STATE_W-1:0]  seed,
	output logic [WORD_W-1:0]   raw,
	output unit_stat_t          stat
);

	localparam int HALF = STATE_W / 2;

	logic [STATE_W-1:0] state_q;
	logic [STATE_W-1:0] inc_q;
	logic               busy_q;
	logic               done_q;
	logic [1:0]         phase_q;
	logic [STATE_W-1:0] p_q;
	logic [STATE_W-1:0] acc_q;
	logic [HALF-1:0]    mul_a;
	logic [HALF-1:0]    mul_b;
	logic [STATE_W-1:0] mixed_w;
	logic [WORD_W-1:0]  mixed;
	logic [4:0]         rot;
	logic [2*WORD_W-1:0] rot_w;

	// XSH-RR permutation of the current state
	always_comb begin
		mixed_w = state_q ^ (state_q >> XSH_SHIFT);
		mixed   = mixed_w[XSH_LOW +: WORD_W];
		rot     = state_q[ROT_LOW +: 5];
		rot_w   = {mixed, mixed} >> rot;
		raw     = rot_w[WORD_W-1:0];
	end

	// pick partial product operands by phase
	always_comb begin
		case (phase_q)
			2'd0: begin
				mul_a = state_q[HALF-1:0];
				mul_b = PCG_MULTIPLIER[STATE_W-1:HALF];
			end
			2'd1: begin
				mul_a = state_q[STATE_W-1:HALF];
				mul_b = PCG_MULTIPLIER[HALF-1:0];
			end
			default: begin
				mul_a = state_q[HALF-1:0];
				mul_b = PCG_MULTIPLIER[HALF-1:0];
			end
		endcase
	end

	// multiplier and accumulator datapath
	always_ff @(posedge clk) begin
		if (busy_q) begin
			p_q <= mul_a * mul_b;
			case (phase_q)
				2'd1: acc_q <= {p_q[HALF-1:0], {HALF{1'b0}}} + inc_q;
				2'd2: acc_q <= acc_q + {p_q[HALF-1:0], {HALF{1'b0}}};
				default: acc_q <= acc_q;
			endcase
		end
	end

	// state, increment and step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PCG_DEFAULT_STATE;
			inc_q   <= PCG_DEFAULT_STREAM;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 2'd0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				phase_q <= phase_q + 2'd1;
				if (phase_q == 2'd3) begin
					state_q <= acc_q + p_q;
					busy_q  <= 1'b0;
					done_q  <= 1'b1;
				end
			end else begin
				case (ctrl.op)
					LCG_STEP: begin
						busy_q  <= 1'b1;
						phase_q <= 2'd0;
					end
					LCG_LOAD_DEFAULT: begin
						state_q <= PCG_DEFAULT_STATE;
						inc_q   <= PCG_DEFAULT_STREAM;
					end
					LCG_LOAD_SEED: begin
						state_q <= '0;
						inc_q   <= {seed[STATE_W-2:0], 1'b1};
					end
					LCG_ADD_DEFAULT: state_q <= state_q + PCG_DEFAULT_STATE;
					default: ;
				endcase
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/pcgb_mod.sv
// ----------------------------------------------------------------------------
// pcgb_mod
// Iterative restoring remainder: one quotient bit a cycle.
// Divisor must be non-zero.
// ----------------------------------------------------------------------------
module pcgb_mod import pcgb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] dividend,
	input  logic [WORD_W-1:0] divisor,
	output logic [WORD_W-1:0] remainder,
	output unit_stat_t        stat
);

	localparam int CNT_W = $clog2(WORD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] num_q;
	logic [WORD_W-1:0] den_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [WORD_W:0]   shifted;
	logic [WORD_W+1:0] trial;

	// trial subtract of the shifted partial remainder
	always_comb begin
		shifted = {rem_q, num_q[WORD_W-1]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			num_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[WORD_W-2:0], 1'b0};
			if (!trial[WORD_W+1]) begin
				rem_q <= trial[WORD_W-1:0];
			end else begin
				rem_q <= shifted[WORD_W-1:0];
			end
		end
	end

	// bit counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	assign remainder = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: rtl/pcg32_bounded_random_core.sv
// ----------------------------------------------------------------------------
// pcg32_bounded_random_core
// PCG32 (XSH-RR) generator with raw draws, bounded draws by rejection and
// remainder, and reinitialisation from the configuration registers.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  in        in_valid / in_ready   command, low_bound, high_bound
//  out       out_valid / out_ready value
//  config    APB psel/penable      paddr[3:0], pwdata/prdata (64 bits)
//
//  Raw draw: one LCG step on the shared multiplier. Bounded draw: two
//  remainder runs on the shared divider, for the threshold and for the
//  accepted draw, plus a further LCG step for every rejected draw.
//  Reinitialise: a default load, or the seed sequence of seed load, step,
//  add of the default state and a second step.
//  Reset loads the default state and stream and clears both registers.
//  in_ready is high only while the sequencer idles; a result waiting on
//  out_ready holds the next result back but not the next item.
// ----------------------------------------------------------------------------
module pcg32_bounded_random_core import pcgb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [WORD_W-1:0]  low_bound,
	input  logic [WORD_W-1:0]  high_bound,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [WORD_W-1:0]  value,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [STATE_W-1:0] pwdata,
	output logic [STATE_W-1:0] prdata,
	output logic               pready
);

	seq_state_t         state_q, state_d;
	logic               use_seed_q;
	logic [STATE_W-1:0] seed_q;
	logic [WORD_W-1:0]  low_q;
	logic [WORD_W-1:0]  range_q;
	logic [WORD_W-1:0]  thresh_q;
	logic [WORD_W-1:0]  raw_q;
	logic [WORD_W-1:0]  res_q;
	logic [WORD_W-1:0]  res_d;
	logic               out_valid_q;
	logic [WORD_W-1:0]  value_q;
	logic [WORD_W-1:0]  in_range;
	logic               accept;
	logic               cfg_wr;
	logic               out_free;
	logic               cap_raw;
	logic               cap_thresh;
	logic               cap_res;
	logic               mod_start;
	logic               mod_sel_draw;
	logic [WORD_W-1:0]  mod_dividend;
	logic [WORD_W-1:0]  mod_divisor;
	logic [WORD_W-1:0]  mod_rem;
	logic [WORD_W-1:0]  lcg_raw;
	lcg_ctrl_t          lcg_ctrl;
	unit_stat_t         lcg_stat;
	unit_stat_t         mod_stat;

	// configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_seed_q <= 1'b0;
			seed_q     <= '0;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_USE_SEED:   use_seed_q <= pwdata[0];
				REG_SEED_VALUE: seed_q     <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_USE_SEED:   prdata = {{(STATE_W-1){1'b0}}, use_seed_q};
			REG_SEED_VALUE: prdata = seed_q;
			default:        prdata = '0;
		endcase
	end

	// handshake helpers
	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign in_range  = high_bound - low_bound + 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign value     = value_q;

	// shared units
	assign mod_dividend = mod_sel_draw ? raw_q : (WORD_W'(0) - range_q);
	assign mod_divisor  = range_q;

	pcgb_lcg u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (lcg_ctrl),
		.seed   (seed_q),
		.raw    (lcg_raw),
		.stat   (lcg_stat)
	);

	pcgb_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_dividend),
		.divisor   (mod_divisor),
		.remainder (mod_rem),
		.stat      (mod_stat)
	);

	// sequencer: next state and unit controls
	always_comb begin
		state_d      = state_q;
		lcg_ctrl.op  = LCG_NONE;
		mod_start    = 1'b0;
		mod_sel_draw = 1'b0;
		cap_raw      = 1'b0;
		cap_thresh   = 1'b0;
		cap_res      = 1'b0;
		res_d        = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (command)
						CMD_RAW: begin
							lcg_ctrl.op = LCG_STEP;
							cap_raw     = 1'b1;
							state_d     = ST_RAW_WAIT;
						end
						CMD_BOUNDED: begin
							if (in_range == '0) begin
								lcg_ctrl.op = LCG_STEP;
								cap_raw     = 1'b1;
								state_d     = ST_RAW_WAIT;
							end else begin
								state_d = ST_THRESH_START;
							end
						end
						CMD_REINIT: begin
							cap_res = 1'b1;
							if (use_seed_q) begin
								lcg_ctrl.op = LCG_LOAD_SEED;
								state_d     = ST_SEED_STEP1;
							end else begin
								lcg_ctrl.op = LCG_LOAD_DEFAULT;
								state_d     = ST_FINISH;
							end
						end
						default: begin
							cap_res = 1'b1;
							state_d = ST_FINISH;
						end
					endcase
				end
			end
			ST_RAW_WAIT: begin
				if (lcg_stat.done) begin
					cap_res = 1'b1;
					res_d   = raw_q;
					state_d = ST_FINISH;
				end
			end
			ST_THRESH_START: begin
				mod_start = 1'b1;
				state_d   = ST_THRESH_WAIT;
			end
			ST_THRESH_WAIT: begin
				if (mod_stat.done) begin
					cap_thresh = 1'b1;
					state_d    = ST_DRAW;
				end
			end
			ST_DRAW: begin
				lcg_ctrl.op = LCG_STEP;
				cap_raw     = 1'b1;
				state_d     = ST_DRAW_WAIT;
			end
			ST_DRAW_WAIT: begin
				if (lcg_stat.done) begin
					if (raw_q >= thresh_q) begin
						mod_start    = 1'b1;
						mod_sel_draw = 1'b1;
						state_d      = ST_MOD_WAIT;
					end else begin
						state_d = ST_DRAW;
					end
				end
			end
			ST_MOD_WAIT: begin
				if (mod_stat.done) begin
					cap_res = 1'b1;
					res_d   = mod_rem + low_q;
					state_d = ST_FINISH;
				end
			end
			ST_SEED_STEP1: begin
				lcg_ctrl.op = LCG_STEP;
				state_d     = ST_SEED_WAIT1;
			end
			ST_SEED_WAIT1: begin
				if (lcg_stat.done) begin
					lcg_ctrl.op = LCG_ADD_DEFAULT;
					state_d     = ST_SEED_STEP2;
				end
			end
			ST_SEED_STEP2: begin
				lcg_ctrl.op = LCG_STEP;
				state_d     = ST_SEED_WAIT2;
			end
			ST_SEED_WAIT2: begin
				if (lcg_stat.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold operands and intermediate results
	always_ff @(posedge clk) begin
		if (accept) begin
			low_q   <= low_bound;
			range_q <= in_range;
		end
		if (cap_raw) begin
			raw_q <= lcg_raw;
		end
		if (cap_thresh) begin
			thresh_q <= mod_rem;
		end
		if (cap_res) begin
			res_q <= res_d;
		end
		if (state_q == ST_FINISH && out_free) begin
			value_q <= res_q;
		end
	end

	// checks
	a_lcg_op_idle: assert property (@(posedge clk) disable iff (!arst_n)
		lcg_stat.busy |-> lcg_ctrl.op == LCG_NONE)
		else $error("LCG command issued during a step");

	a_mod_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mod_stat.busy |-> !mod_start)
		else $error("remainder unit restarted while busy");

	a_mod_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mod_stat.done |-> (state_q == ST_THRESH_WAIT || state_q == ST_MOD_WAIT))
		else $error("remainder finished outside a waiting state");

	a_lcg_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		lcg_stat.done |-> (state_q == ST_RAW_WAIT || state_q == ST_DRAW_WAIT ||
			state_q == ST_SEED_WAIT1 || state_q == ST_SEED_WAIT2))
		else $error("LCG step finished outside a waiting state");

endmodule

// File: tb/pcg32_draw_checker.sv
// ----------------------------------------------------------------------------
// pcg32_draw_checker
// Watches the item, result and register ports of the PCG32 core. It keeps its
// own generator state and register copies, predicts the value of every
// accepted item and compares it with the results in order.
// ----------------------------------------------------------------------------
module pcg32_draw_checker import pcgb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         command,
	input  logic [WORD_W-1:0]  low_bound,
	input  logic [WORD_W-1:0]  high_bound,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [WORD_W-1:0]  value,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [STATE_W-1:0] pwdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);

	localparam int REPORT_MAX = 30;

	// generator state and register copies
	logic [STATE_W-1:0] lcg_st;
	logic [STATE_W-1:0] lcg_inc;
	logic [STATE_W-1:0] seed_word;
	logic               seed_mode;

	// values still owed by the core, oldest first
	logic [WORD_W-1:0] owed_values [$];

	int errs = 0;
	int seen = 0;

	// one XSH-RR output of the current state, then advance the LCG
	function automatic logic [WORD_W-1:0] pcg_draw();
		logic [STATE_W-1:0] old;
		logic [STATE_W-1:0] shifted;
		logic [WORD_W-1:0]  mixed;
		logic [4:0]         rot;
		logic [2*WORD_W-1:0] twice;
		old     = lcg_st;
		lcg_st  = old * PCG_MULTIPLIER + lcg_inc;
		shifted = ((old >> XSH_SHIFT) ^ old) >> XSH_LOW;
		mixed   = shifted[WORD_W-1:0];
		shifted = old >> ROT_LOW;
		rot     = shifted[4:0];
		twice   = {mixed, mixed} >> rot;
		return twice[WORD_W-1:0];
	endfunction

	// draw in [lo, hi] with rejection; a span that wraps to zero gives a raw draw
	function automatic logic [WORD_W-1:0] bounded_draw(input logic [WORD_W-1:0] lo,
			input logic [WORD_W-1:0] hi);
		logic [WORD_W-1:0] span;
		logic [WORD_W-1:0] floor_v;
		logic [WORD_W-1:0] r;
		span = hi - lo + 32'd1;
		if (span == '0)
			return pcg_draw();
		floor_v = (32'd0 - span) % span;
		do
			r = pcg_draw();
		while (r < floor_v);
		return (r % span) + lo;
	endfunction

	// load defaults, or run the seeding sequence
	function automatic void reload_generator();
		if (seed_mode) begin
			lcg_st  = '0;
			lcg_inc = (seed_word << 1) | 64'd1;
			void'(pcg_draw());
			lcg_st  = lcg_st + PCG_DEFAULT_STATE;
			void'(pcg_draw());
		end else begin
			lcg_st  = PCG_DEFAULT_STATE;
			lcg_inc = PCG_DEFAULT_STREAM;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [WORD_W-1:0] want;
		if (!arst_n) begin
			lcg_st    = PCG_DEFAULT_STATE;
			lcg_inc   = PCG_DEFAULT_STREAM;
			seed_mode = 1'b0;
			seed_word = '0;
			owed_values.delete();
		end else begin
			// track register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_SEED_VALUE)
					seed_word = pwdata;
				else
					seed_mode = pwdata[0];
			end

			// predict each accepted item
			if (in_valid && in_ready) begin
				case (command)
					CMD_RAW:     want = pcg_draw();
					CMD_BOUNDED: want = bounded_draw(low_bound, high_bound);
					CMD_REINIT: begin
						reload_generator();
						want = '0;
					end
					default:     want = '0;
				endcase
				owed_values.push_back(want);
			end

			// compare each accepted result with the oldest owed value
			if (out_valid && out_ready) begin
				seen++;
				if (owed_values.size() == 0) begin
					errs++;
					if (errs <= REPORT_MAX)
						$error("value: unexpected item, actual %h", value);
				end else begin
					want = owed_values.pop_front();
					if (value !== want) begin
						errs++;
						if (errs <= REPORT_MAX)
							$error("value mismatch: expected %h, actual %h", want, value);
					end
				end
			end
		end
		fail_count <= errs;
		pending    <= owed_values.size();
		checked    <= seen;
	end

endmodule

// File: tb/tb_pcg32_bounded_random_core.sv
// ----------------------------------------------------------------------------
// tb_pcg32_bounded_random_core
// Drives raw, bounded, reinitialise and spare-code items into the PCG32 core
// under bursty input and a stalling receiver, across several register
// settings, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_pcg32_bounded_random_core;
	import pcgb_pkg::*;

	localparam logic [1:0] CMD_SPARE   = 2'd3;
	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         PHASE_ITEMS = 250;
	localparam int         HOLD_CYCLES = 500;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_ready;
	logic [1:0]         command    = CMD_RAW;
	logic [WORD_W-1:0]  low_bound  = '0;
	logic [WORD_W-1:0]  high_bound = '0;
	logic               out_valid;
	logic               out_ready  = 1'b0;
	logic [WORD_W-1:0]  value;
	logic               psel       = 1'b0;
	logic               penable    = 1'b0;
	logic               pwrite     = 1'b0;
	logic [3:0]         paddr      = '0;
	logic [STATE_W-1:0] pwdata     = '0;
	logic [STATE_W-1:0] prdata;
	logic               pready;

	int fail_count;
	int pending;
	int checked;

	int cycle_cnt    = 0;
	int burst_left   = 0;
	int settings_cnt = 0;
	int issued [4]   = '{0, 0, 0, 0};

	// receiver state
	int hold_req   = 0;
	int hold_seen  = 0;
	int hold_left  = 0;
	int stall_mode = 0;
	int mode_left  = 0;

	pcg32_bounded_random_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	pcg32_draw_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.low_bound  (low_bound),
		.high_bound (high_bound),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	always #6 clk = ~clk;

	// give up on a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAIL pcg32_bounded_random_core");
			$finish;
		end
	end

	// receiver: long hold on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(20, 200);
			end
			mode_left--;
			case (stall_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= 1'($urandom_range(0, 1));
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ((cycle_cnt % 8) < 5);
			endcase
		end
	end

	// offer one item, with a random gap between bursts; return once accepted
	task automatic send_item(input logic [1:0] c, input logic [WORD_W-1:0] lo,
			input logic [WORD_W-1:0] hi);
		if (burst_left == 0) begin
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid   <= 1'b1;
		command    <= c;
		low_bound  <= lo;
		high_bound <= hi;
		do
			@(posedge clk);
		while (!in_ready);
		issued[c]++;
	endtask

	// drop valid and wait until every owed result is in and the core idles
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0 || !in_ready);
	endtask

	// write one register: setup cycle, then access cycle
	task automatic reg_write(input logic sel, input logic [STATE_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_regs(input logic use_seed, input logic [STATE_W-1:0] seed);
		reg_write(REG_USE_SEED, {{(STATE_W-1){1'b0}}, use_seed});
		reg_write(REG_SEED_VALUE, seed);
		settings_cnt++;
	endtask

	// one random item, weighted towards bounded draws of varied span
	task automatic random_item();
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		int pick;
		pick = $urandom_range(0, 99);
		lo   = $urandom;
		hi   = $urandom;
		if (pick < 38) begin
			send_item(CMD_RAW, lo, hi);
		end else if (pick < 88) begin
			case ($urandom_range(0, 5))
				0: hi = lo + $urandom_range(0, 15);
				// span wraps to zero
				1: hi = lo - 32'd1;
				// span just over half: about half the draws are rejected
				2: hi = lo + 32'h8000_0000 + $urandom_range(0, 255);
				3: begin
					lo = $urandom_range(0, 3);
					hi = 32'hffff_ffff - $urandom_range(0, 3);
				end
				4: hi = lo + $urandom_range(0, 1 << 20);
				default: ;
			endcase
			send_item(CMD_BOUNDED, lo, hi);
		end else if (pick < 96) begin
			send_item(CMD_REINIT, lo, hi);
		end else begin
			send_item(CMD_SPARE, lo, hi);
		end
	endtask

	initial begin : stimulus
		logic             use_seed;
		logic [STATE_W-1:0] seed;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: raw draws, span corners, spare code, default reload
		send_item(CMD_RAW, 32'h0000_0000, 32'h0000_0000);
		send_item(CMD_RAW, 32'hffff_ffff, 32'hffff_ffff);
		send_item(CMD_BOUNDED, 32'h0000_0000, 32'h0000_0000);
		send_item(CMD_BOUNDED, 32'h0000_0000, 32'hffff_ffff);
		send_item(CMD_BOUNDED, 32'd5, 32'd4);
		send_item(CMD_BOUNDED, 32'd10, 32'd3);
		send_item(CMD_BOUNDED, 32'hffff_ffff, 32'hffff_ffff);
		send_item(CMD_BOUNDED, 32'h0000_0000, 32'h8000_0000);
		send_item(CMD_BOUNDED, 32'h8000_0000, 32'hffff_ffff);
		send_item(CMD_BOUNDED, 32'd100, 32'd106);
		send_item(CMD_SPARE, 32'hffff_ffff, 32'hffff_ffff);
		send_item(CMD_RAW, 32'h0, 32'h0);
		send_item(CMD_REINIT, 32'h0, 32'h0);
		send_item(CMD_RAW, 32'h0, 32'h0);
		send_item(CMD_SPARE, 32'h0, 32'h0);
		drain();

		// seeded reload at both seed extremes
		set_regs(1'b1, 64'h0);
		send_item(CMD_REINIT, 32'h0, 32'h0);
		send_item(CMD_RAW, 32'h0, 32'h0);
		send_item(CMD_BOUNDED, 32'd0, 32'd9);
		drain();
		set_regs(1'b1, 64'hffff_ffff_ffff_ffff);
		send_item(CMD_REINIT, 32'h0, 32'h0);
		send_item(CMD_RAW, 32'h0, 32'h0);
		send_item(CMD_BOUNDED, 32'd7, 32'd6);
		drain();

		// random phases, each under its own register setting
		for (int p = 0; p < 8; p++) begin
			use_seed = 1'($urandom_range(0, 1));
			seed     = {$urandom, $urandom};
			case (p)
				0: use_seed = 1'b0;
				1: begin
					use_seed = 1'b1;
					seed     = 64'h0;
				end
				2: begin
					use_seed = 1'b1;
					seed     = 64'hffff_ffff_ffff_ffff;
				end
				5: begin
					use_seed = 1'b1;
					seed     = 64'h8000_0000_0000_0000;
				end
				default: ;
			endcase
			set_regs(use_seed, seed);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// hold the receiver off so the core backs up
				if ((p == 3 || p == 6) && i == 100)
					hold_req <= hold_req + 1;
				random_item();
			end
			drain();
		end

		// let any stray result show up
		repeat (300) @(posedge clk);

		$display("Covered %0d raw, %0d bounded, %0d reinitialise and %0d spare-code items",
			issued[CMD_RAW], issued[CMD_BOUNDED], issued[CMD_REINIT], issued[CMD_SPARE]);
		$display("over %0d register settings; %0d results compared in %0d cycles",
			settings_cnt, checked, cycle_cnt);
		if (fail_count == 0)
			$display("PASS pcg32_bounded_random_core");
		else
			$display("FAIL pcg32_bounded_random_core");
		$finish;
	end

endmodule
